@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file, arb_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion with asynchronous active-low reset disable.
`define ARB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

@@ rtl/arb_pkg.sv @@
// Shared types and constants for the aged retransmit buffer.
// No dependencies.
package arb_pkg;
  localparam int unsigned IdWidth   = 32;
  localparam int unsigned TimeWidth = 32;
  localparam int unsigned AgeWidth  = 16;
  localparam logic [AgeWidth-1:0] AgeLimitReset = 16'd120;

  typedef enum logic {
    KIND_ADD  = 1'b0,
    KIND_FIND = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [TimeWidth-1:0] now_time;
    logic [IdWidth-1:0]   piece_id;
    logic [IdWidth-1:0]   subpiece_id;
  } cmd_hdr_t;
endpackage

@@ rtl/arb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module arb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ rtl/arb_front.sv @@
// Front end: accepts command beats into a two-entry queue.
// Depends on arb_pkg.
module arb_front import arb_pkg::*; #(
  parameter int unsigned PayloadWidth = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  cmd_hdr_t                hdr_i,
  input  logic [PayloadWidth-1:0] data_i,
  output logic                    cmd_valid_o,
  input  logic                    cmd_ready_i,
  output cmd_hdr_t                hdr_o,
  output logic [PayloadWidth-1:0] data_o
);
  cmd_hdr_t                hdr_q [2];
  logic [PayloadWidth-1:0] data_q [2];
  logic                    wr_q, rd_q;
  logic [1:0]              cnt_q;
  logic                    push, pop;

  assign ready_o     = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign push        = valid_i && ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign hdr_o       = hdr_q[rd_q];
  assign data_o      = data_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      hdr_q[wr_q]  <= hdr_i;
      data_q[wr_q] <= data_i;
    end
  end
endmodule

@@ rtl/arb_back.sv @@
// Back end: ring storage, age eviction, find scan and replay.
// Depends on arb_pkg and arb_ram.
module arb_back import arb_pkg::*; #(
  parameter int unsigned Depth        = 64,
  parameter int unsigned PayloadWidth = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [AgeWidth-1:0]     age_limit_i,
  input  logic                    cmd_valid_i,
  output logic                    cmd_ready_o,
  input  cmd_hdr_t                hdr_i,
  input  logic [PayloadWidth-1:0] data_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [IdWidth-1:0]      piece_o,
  output logic [IdWidth-1:0]      subpiece_o,
  output logic [PayloadWidth-1:0] payload_o,
  output logic                    last_o
);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned EW = TimeWidth + 2 * IdWidth + PayloadWidth;

  typedef enum logic [2:0] {
    S_IDLE, S_AGE, S_SCAN, S_CMP, S_RD, S_OUT
  } state_e;

  state_e                state_q;
  logic [AW-1:0]         oldest_q;
  logic [CW-1:0]         count_q;
  logic [CW-1:0]         idx_q;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [EW-1:0]         wdata, rdata;
  logic [TimeWidth-1:0]  r_time, diff;
  logic [IdWidth-1:0]    r_piece, r_sub;
  logic [PayloadWidth-1:0] r_data;
  logic                  evict;
  logic [CW-1:0]         cnt_ev;
  logic [AW-1:0]         old_ev;

  assign {r_time, r_piece, r_sub, r_data} = rdata;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] b, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, b} + {1'b0, o};
    if (s >= (CW+1)'(Depth)) s = s - (CW+1)'(Depth);
    return s[AW-1:0];
  endfunction

  assign raddr = (state_q == S_IDLE) ? oldest_q : wrap(oldest_q, idx_q);

  // eviction decision on oldest entry, evaluated in S_AGE
  assign diff   = hdr_i.now_time - r_time;
  assign evict  = (count_q != '0) && !diff[TimeWidth-1] &&
                  (diff > {{(TimeWidth-AgeWidth){1'b0}}, age_limit_i});
  assign cnt_ev = evict ? count_q - CW'(1) : count_q;
  assign old_ev = evict ? wrap(oldest_q, CW'(1)) : oldest_q;

  assign we    = (state_q == S_AGE);
  assign waddr = (cnt_ev == CW'(Depth)) ? old_ev : wrap(old_ev, cnt_ev);
  assign wdata = {hdr_i.now_time, hdr_i.piece_id, hdr_i.subpiece_id, data_i};

  arb_ram #(.Width(EW), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign cmd_ready_o = (state_q == S_AGE) ||
                       (state_q == S_SCAN && idx_q == count_q) ||
                       (state_q == S_OUT && ready_i && idx_q == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      oldest_q   <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      valid_o    <= 1'b0;
      last_o     <= 1'b0;
      piece_o    <= '0;
      subpiece_o <= '0;
      payload_o  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          idx_q   <= '0;
          if (cmd_valid_i) begin
            state_q <= (hdr_i.kind == KIND_ADD) ? S_AGE : S_SCAN;
          end
        end
        S_AGE: begin
          if (cnt_ev == CW'(Depth)) begin
            oldest_q <= wrap(old_ev, CW'(1));
            count_q  <= cnt_ev;
          end else begin
            oldest_q <= old_ev;
            count_q  <= cnt_ev + CW'(1);
          end
          state_q <= S_IDLE;
        end
        // scan: read address idx, compare the registered read data in S_CMP
        S_SCAN: begin
          if (idx_q == count_q) state_q <= S_IDLE;
          else                  state_q <= S_CMP;
        end
        S_CMP: begin
          if (r_piece == hdr_i.piece_id && r_sub == hdr_i.subpiece_id) begin
            state_q <= S_OUT;
            valid_o <= 1'b1;
            last_o  <= (idx_q + CW'(1) == count_q);
            piece_o <= r_piece; subpiece_o <= r_sub; payload_o <= r_data;
            idx_q   <= idx_q + CW'(1);
          end else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_SCAN;
          end
        end
        S_RD: begin
          valid_o <= 1'b1;
          last_o  <= (idx_q + CW'(1) == count_q);
          piece_o <= r_piece; subpiece_o <= r_sub; payload_o <= r_data;
          idx_q   <= idx_q + CW'(1);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (ready_i) begin
            valid_o <= 1'b0;
            state_q <= (idx_q == count_q) ? S_IDLE : S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/aged_retransmit_buffer.sv @@
// Top level of the aged retransmit buffer: config register, front queue, back end.
// Depends on arb_pkg, arb_front, arb_back.
//
// Ring of up to DEPTH sent pieces in one RAM with registered read. An add beat
// reads the oldest entry's time, then writes and evicts. A find beat reads
// (S_SCAN) and compares (S_CMP) stored entries from the oldest, then replays
// the match and each later entry (S_RD, S_OUT), all through the RAM's single
// read port. The back end handles one beat at a time. The front queue holds
// two beats so inputs are taken while the back end is busy.
module aged_retransmit_buffer import arb_pkg::*; #(
  parameter int unsigned DEPTH         = 64,
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [AgeWidth-1:0]      cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     kind_i,
  input  logic [TimeWidth-1:0]     now_time_i,
  input  logic [IdWidth-1:0]       piece_id_i,
  input  logic [IdWidth-1:0]       subpiece_id_i,
  input  logic [PAYLOAD_WIDTH-1:0] payload_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [IdWidth-1:0]       out_piece_id_o,
  output logic [IdWidth-1:0]       out_subpiece_id_o,
  output logic [PAYLOAD_WIDTH-1:0] out_payload_o,
  output logic                     last_o
);
  logic [AgeWidth-1:0]      age_limit_q;
  cmd_hdr_t                 hdr_in, hdr_q;
  logic [PAYLOAD_WIDTH-1:0] data_q;
  logic                     cmd_valid, cmd_ready;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) age_limit_q <= AgeLimitReset;
    else if (cfg_valid_i) age_limit_q <= cfg_data_i;
  end

  assign hdr_in = '{kind: kind_e'(kind_i), now_time: now_time_i,
                    piece_id: piece_id_i, subpiece_id: subpiece_id_i};

  arb_front #(.PayloadWidth(PAYLOAD_WIDTH)) u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .ready_o(in_ready_o),
    .hdr_i(hdr_in), .data_i(payload_i),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready),
    .hdr_o(hdr_q), .data_o(data_q)
  );

  arb_back #(.Depth(DEPTH), .PayloadWidth(PAYLOAD_WIDTH)) u_back (
    .clk_i, .rst_ni, .age_limit_i(age_limit_q),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .hdr_i(hdr_q), .data_i(data_q),
    .valid_o(out_valid_o), .ready_i(out_ready_i),
    .piece_o(out_piece_id_o), .subpiece_o(out_subpiece_id_o),
    .payload_o(out_payload_o), .last_o(last_o)
  );
endmodule

@@ rtl/arb_checker.sv @@
// Port-level checker for the aged retransmit buffer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module arb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic last_o,
  input logic in_valid_i,
  input logic in_ready_o
);
  logic out_stall, out_take, in_stall;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_take  = out_valid_o && out_ready_i;
  assign in_stall  = in_valid_i && !in_ready_o;

  `ARB_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o, "out beat dropped")
  `ARB_ASSERT(a_last_hold, clk_i, rst_ni, out_stall |=> $stable(last_o), "last changed")
  `ARB_ASSERT(a_out_gap, clk_i, rst_ni, out_take |=> !out_valid_o, "beats too close")
  `ARB_ASSERT(a_in_hold, clk_i, rst_ni, in_stall |=> in_valid_i, "in beat withdrawn")
endmodule

bind aged_retransmit_buffer arb_checker u_arb_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .last_o,
  .in_valid_i, .in_ready_o
);

@@ verif/tb_top.sv @@
// Self-checking testbench for aged_retransmit_buffer: drives add and find beats,
// predicts replays with a ring model and compares each output beat. Uses arb_pkg.
`timescale 1ns / 100ps

module tb_top;
  import arb_pkg::*;

  localparam int unsigned Depth     = 64;
  localparam int unsigned PayWidth  = 64;
  localparam int unsigned CycleCap  = 1500000;

  typedef struct packed {
    logic [IdWidth-1:0]  piece;
    logic [IdWidth-1:0]  subpiece;
    logic [PayWidth-1:0] data;
    logic                last;
  } replay_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [AgeWidth-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic kind_i = KIND_ADD;
  logic [TimeWidth-1:0] now_time_i = '0;
  logic [IdWidth-1:0] piece_id_i = '0;
  logic [IdWidth-1:0] subpiece_id_i = '0;
  logic [PayWidth-1:0] payload_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [IdWidth-1:0] out_piece_id_o;
  logic [IdWidth-1:0] out_subpiece_id_o;
  logic [PayWidth-1:0] out_payload_o;
  logic last_o;

  aged_retransmit_buffer #(.DEPTH(Depth), .PAYLOAD_WIDTH(PayWidth)) u_dut (.*);

  always #1 clk_i = ~clk_i;

  // ring model
  logic [AgeWidth-1:0]  age_limit_q = AgeLimitReset;
  logic [TimeWidth-1:0] ring_time [Depth];
  logic [IdWidth-1:0]   ring_piece [Depth];
  logic [IdWidth-1:0]   ring_sub [Depth];
  logic [PayWidth-1:0]  ring_data [Depth];
  int unsigned ring_head = 0;
  int unsigned ring_fill = 0;
  replay_t replay_q[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 21;
  int unsigned hold_cycles = 0;
  logic [TimeWidth-1:0] clock_s = 32'd1000;

  task automatic report(input string what);
    errors++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  task automatic predict_add(input logic [TimeWidth-1:0] t, input logic [IdWidth-1:0] p,
                             input logic [IdWidth-1:0] s, input logic [PayWidth-1:0] d);
    logic [TimeWidth-1:0] age;
    int unsigned slot;
    if (ring_fill > 0) begin
      age = t - ring_time[ring_head];
      if (!age[TimeWidth-1] && age > {16'd0, age_limit_q}) begin
        ring_head = (ring_head + 1) % Depth;
        ring_fill--;
      end
    end
    if (ring_fill == Depth) begin
      slot = ring_head;
      ring_head = (ring_head + 1) % Depth;
    end else begin
      slot = (ring_head + ring_fill) % Depth;
      ring_fill++;
    end
    ring_time[slot] = t;
    ring_piece[slot] = p;
    ring_sub[slot] = s;
    ring_data[slot] = d;
  endtask

  task automatic predict_find(input logic [IdWidth-1:0] p, input logic [IdWidth-1:0] s);
    int start;
    int unsigned k;
    replay_t r;
    start = -1;
    for (int i = 0; i < ring_fill; i++) begin
      k = (ring_head + i) % Depth;
      if (start < 0 && ring_piece[k] == p && ring_sub[k] == s) start = i;
    end
    if (start >= 0) begin
      for (int i = start; i < ring_fill; i++) begin
        k = (ring_head + i) % Depth;
        r.piece = ring_piece[k];
        r.subpiece = ring_sub[k];
        r.data = ring_data[k];
        r.last = (i + 1 == ring_fill);
        replay_q.insert(replay_q.size(), r);
      end
    end
  endtask

  // valid stays up on return; the next send drops it or drives a new beat, and drain drops it
  task automatic send_beat(input kind_e k, input logic [TimeWidth-1:0] t,
                           input logic [IdWidth-1:0] p, input logic [IdWidth-1:0] s,
                           input logic [PayWidth-1:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    kind_i <= k;
    now_time_i <= t;
    piece_id_i <= p;
    subpiece_id_i <= s;
    payload_i <= d;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (k == KIND_ADD) predict_add(t, p, s, d);
    else predict_find(p, s);
    @(negedge clk_i);
  endtask

  task automatic add_piece(input logic [IdWidth-1:0] p, input logic [IdWidth-1:0] s);
    clock_s += $urandom_range(3);
    send_beat(KIND_ADD, clock_s, p, s, {$urandom, $urandom});
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (replay_q.size() != 0) @(negedge clk_i);
    repeat (2 * Depth + 20) @(negedge clk_i);
  endtask

  task automatic write_age_limit(input logic [AgeWidth-1:0] v);
    drain();
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    age_limit_q = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // output handshake and compare
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (replay_q.size() == 0) begin
        report("output beat with nothing expected");
      end else begin
        replay_t r;
        r = replay_q[0];
        replay_q.delete(0);
        if (out_piece_id_o !== r.piece) report("out_piece_id");
        if (out_subpiece_id_o !== r.subpiece) report("out_subpiece_id");
        if (out_payload_o !== r.data) report("out_payload");
        if (last_o !== r.last) report("last");
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("FAIL aged_retransmit_buffer");
      $finish;
    end
  end

  task automatic test_directed();
    // find on the empty ring, then adds and finds at the extremes of each field
    send_beat(KIND_FIND, 32'h0, 32'h0, 32'h0, '0);          // empty ring
    add_piece(32'h0, 32'h0);
    send_beat(KIND_ADD, clock_s, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
    send_beat(KIND_ADD, clock_s, 32'h5, 32'h7, 64'h0);
    add_piece(32'h5, 32'h7);                                // duplicate ids
    send_beat(KIND_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
    send_beat(KIND_FIND, clock_s, 32'h5, 32'h7, '0);        // oldest duplicate wins
    send_beat(KIND_FIND, clock_s, 32'h0, 32'h0, '0);
    send_beat(KIND_FIND, clock_s, 32'h1234, 32'h0, '0);     // miss
    // time moving backwards never evicts
    send_beat(KIND_ADD, clock_s - 32'd5000, 32'h9, 32'h9, 64'hA5A5);
    // large forward jump evicts one
    clock_s += 32'd1000;
    add_piece(32'hA, 32'hA);
    send_beat(KIND_FIND, clock_s, 32'h0, 32'h0, '0);
    send_beat(KIND_FIND, clock_s, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
  endtask

  task automatic test_full_ring();
    // age limit max so nothing ages out; overwrite oldest when full
    write_age_limit(16'hFFFF);
    for (int i = 0; i < Depth + 6; i++) add_piece(32'h100 + i, i);
    send_beat(KIND_FIND, clock_s, 32'h100 + 6, 32'd6, '0);  // full 64-beat replay
    send_beat(KIND_FIND, clock_s, 32'h100, 32'd0, '0);      // overwritten, miss
  endtask

  task automatic test_backpressure();
    // receiver holds off while finds pile up
    for (int i = 0; i < 4; i++) send_beat(KIND_FIND, clock_s, 32'h100 + 40 + i, 40 + i, '0);
    hold_cycles = 600;
    for (int i = 0; i < 4; i++) send_beat(KIND_FIND, clock_s, 32'h100 + 50, 50, '0);
    drain();
  endtask

  task automatic test_random(input int unsigned beats);
    logic [IdWidth-1:0] p;
    for (int unsigned n = 0; n < beats; n++) begin
      if (n == beats / 2) idle_pct = 0;
      if (n == beats / 2 + 60) idle_pct = 21;
      if ($urandom_range(99) < 70) begin
        p = ($urandom_range(9) == 0) ? $urandom : $urandom_range(15);
        if ($urandom_range(19) == 0) begin
          send_beat(KIND_ADD, $urandom, p, $urandom_range(3), {$urandom, $urandom});
        end else begin
          clock_s += $urandom_range(age_limit_q > 8 ? 8 : age_limit_q + 2);
          send_beat(KIND_ADD, clock_s, p, $urandom_range(3), {$urandom, $urandom});
        end
      end else begin
        p = ($urandom_range(9) == 0) ? $urandom : $urandom_range(15);
        send_beat(KIND_FIND, $urandom, p, $urandom_range(3), {$urandom, $urandom});
      end
    end
    idle_pct = 21;
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_full_ring();
    test_backpressure();
    write_age_limit(16'd0);
    test_random(60);
    write_age_limit(16'd20);
    test_random(120);
    write_age_limit(16'd120);
    test_random(60);
    drain();
    if (errors == 0) begin
      $display("PASS aged_retransmit_buffer");
    end else begin
      $display("FAIL aged_retransmit_buffer");
    end
    $finish;
  end

endmodule
